// File: hw/rtl/xif_pkg.sv
// shared constants and types of the xml indent formatter
package xif_pkg;

	// field and state widths
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned DEPTH_W = 5;
	localparam int unsigned CNT_W = DEPTH_W + 1;

	// default for the depth ceiling
	localparam int unsigned MAX_DEPTH_DEF = 31;

	// characters the formatter reacts to
	localparam logic [BYTE_W-1:0] CH_LT = 8'h3C;
	localparam logic [BYTE_W-1:0] CH_GT = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_BANG = 8'h21;
	localparam logic [BYTE_W-1:0] CH_DASH = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_LBRK = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_RBRK = 8'h5D;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_QUEST = 8'h3F;
	localparam logic [BYTE_W-1:0] CH_NL = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SP = 8'h20;
	localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_NL   = 4'b0010,
		S_SP   = 4'b0100,
		S_BYTE = 4'b1000
	} seq_state_t;

endpackage

// File: hw/rtl/xml_indent_formatter_core.sv
// xml indent formatter: one text byte in, the byte plus line breaks and indentation out
//
//   channel | signals                                       | beat
//   in      | in_valid, in_ready, this_byte, lookahead_byte | one xml byte and the byte after it
//   out     | out_valid, out_ready, out_byte, run_end       | one formatted byte, run_end on last
//
// an input byte is decoded in its accept cycle; the sequencer then sends one output beat per
// cycle unless the output stalls: a byte alone goes out as its own beat, a byte with a line
// break also gets a newline and two spaces per level of the depth that the break indents to.
// the indentation run is counted down by the single shared space counter.
// in_ready is high only while the sequencer is idle; a zero byte is taken and dropped.
// out_valid stalls the sequencer when out_ready is low; the output register parts the sides.
// arst_n clears depth, flags and the previous byte, and sets the line-start flag.
module xml_indent_formatter_core #(
	parameter int unsigned MAX_DEPTH = xif_pkg::MAX_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [xif_pkg::BYTE_W-1:0] this_byte,
	input  logic [xif_pkg::BYTE_W-1:0] lookahead_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [xif_pkg::BYTE_W-1:0] out_byte,
	output logic                      run_end
);
	import xif_pkg::*;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

	// formatter state
	logic [BYTE_W-1:0]  prev_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               line_start_q;
	logic               in_comment_q;
	logic               in_cdata_q;

	// sequencer
	seq_state_t         state_q;
	logic [BYTE_W-1:0]  cur_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               post_q;
	logic               after_q;
	logic [DEPTH_W-1:0] post_depth_q;

	// output register
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               run_end_q;

	logic               accept;
	logic               adv;
	logic               emit;

	// decode of the accepted byte
	logic               set_c, set_d, cm, cd, c_end, d_end, verbatim;
	logic               is_lt, is_gt, pre_brk, post_brk, opens;
	logic [DEPTH_W-1:0] d1, d2, d3;

	// beat chosen by the sequencer
	logic [BYTE_W-1:0]  beat_byte;
	logic               beat_last;
	seq_state_t         state_d;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign adv = !out_valid_q || out_ready;
	assign emit = adv && (state_q != S_IDLE);

	// byte classification and depth updates
	always_comb begin
		set_c = (prev_q == CH_LT) && (this_byte == CH_BANG) && (lookahead_byte == CH_DASH);
		set_d = (prev_q == CH_LT) && (this_byte == CH_BANG) && (lookahead_byte == CH_LBRK);
		cm = in_comment_q || set_c;
		cd = in_cdata_q || set_d;
		c_end = cm && (prev_q == CH_DASH) && (this_byte == CH_GT);
		d_end = cd && (prev_q == CH_RBRK) && (this_byte == CH_GT);
		verbatim = (cm || cd) && !c_end && !d_end;
		is_lt = (this_byte == CH_LT);
		is_gt = (this_byte == CH_GT);
		// closing tag lowers depth before its break
		d1 = depth_q;
		if (is_lt && (lookahead_byte == CH_SLASH) && (depth_q != '0)) begin
			d1 = depth_q - DEPTH_W'(1);
		end
		pre_brk = is_lt && !line_start_q;
		opens = is_lt && (lookahead_byte != CH_SLASH) && (lookahead_byte != CH_QUEST)
			&& (lookahead_byte != CH_BANG);
		d2 = d1;
		if (opens && (d1 < DEPTH_MAX)) begin
			d2 = d1 + DEPTH_W'(1);
		end
		// self-closing tag end lowers depth
		d3 = d2;
		if (is_gt && (prev_q == CH_SLASH) && (d2 != '0)) begin
			d3 = d2 - DEPTH_W'(1);
		end
		post_brk = is_gt && (lookahead_byte != CH_LT);
	end

	// formatter state update at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= CH_NUL;
			depth_q <= '0;
			line_start_q <= 1'b1;
			in_comment_q <= 1'b0;
			in_cdata_q <= 1'b0;
		end else if (accept && (this_byte != CH_NUL)) begin
			prev_q <= this_byte;
			in_comment_q <= cm && !c_end;
			in_cdata_q <= cd && !d_end;
			if (!verbatim) begin
				depth_q <= d3;
				line_start_q <= post_brk;
			end
		end
	end

	// beat contents and next sequencer state
	always_comb begin
		beat_byte = cur_q;
		beat_last = 1'b0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				beat_byte = cur_q;
			end
			S_NL: begin
				beat_byte = CH_NL;
				beat_last = after_q && (cnt_q == '0);
				if (cnt_q != '0) begin
					state_d = S_SP;
				end else begin
					state_d = after_q ? S_IDLE : S_BYTE;
				end
			end
			S_SP: begin
				beat_byte = CH_SP;
				beat_last = after_q && (cnt_q == CNT_W'(1));
				if (cnt_q == CNT_W'(1)) begin
					state_d = after_q ? S_IDLE : S_BYTE;
				end
			end
			S_BYTE: begin
				beat_byte = cur_q;
				beat_last = !post_q;
				state_d = post_q ? S_NL : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer and shared space counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			after_q <= 1'b0;
			post_q <= 1'b0;
			cnt_q <= '0;
		end else if (accept) begin
			if (this_byte != CH_NUL) begin
				after_q <= 1'b0;
				post_q <= !verbatim && post_brk;
				cnt_q <= {d1, 1'b0};
				state_q <= (!verbatim && pre_brk) ? S_NL : S_BYTE;
			end
		end else if (emit) begin
			state_q <= state_d;
			if (state_q == S_SP) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (state_q == S_BYTE) begin
				after_q <= 1'b1;
				cnt_q <= {post_depth_q, 1'b0};
			end
		end
	end

	// payload held for the sequencer
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= this_byte;
			post_depth_q <= d3;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= beat_byte;
			run_end_q <= beat_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign run_end = run_end_q;

endmodule

// File: hw/rtl/xif_checker.sv
// port-level checks of the xml indent formatter, bound to the top level
module xif_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [xif_pkg::BYTE_W-1:0] this_byte,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [xif_pkg::BYTE_W-1:0] out_byte,
	input logic                      run_end
);
	import xif_pkg::*;

	// a text byte keeps the input closed while its beats go out
	a_busy_after_text: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (this_byte != CH_NUL)) |=> !in_ready)
		else $error("input open right after a text byte");

	// a zero byte makes no beats
	a_zero_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (this_byte == CH_NUL)) |=> in_ready)
		else $error("zero byte started a run");

	// a beat that is not the last of its run means more work is pending
	a_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !run_end) |-> !in_ready)
		else $error("input open in the middle of a run");

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(run_end)))
		else $error("output beat changed under stall");

endmodule

bind xml_indent_formatter_core xif_checker u_xif_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.this_byte (this_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.run_end   (run_end)
);
